FILE: src/mexp_pkg.sv
// Package for the modular exponentiation block.
// Holds the default operand width, the field widths and the result kind codes; no dependencies.
package mexp_pkg;
    localparam int WIDTH_DEF = 32;
    localparam int FIELD_W   = 32;

    localparam logic [1:0] KIND_NORMAL = 2'd0;
    localparam logic [1:0] KIND_ERROR  = 2'd1;
    localparam logic [1:0] KIND_ONE    = 2'd2;
endpackage

FILE: src/mexp_if.sv
// Valid/ready channel carrying the exponentiation request and result words.
// Depends on mexp_pkg for field widths.
interface mexp_in_if;
    logic                        valid;
    logic                        ready;
    logic [mexp_pkg::FIELD_W-1:0] base;
    logic [mexp_pkg::FIELD_W-1:0] exponent;
    logic [mexp_pkg::FIELD_W-1:0] modulus;
    modport source (output valid, base, exponent, modulus, input ready);
    modport sink   (input valid, base, exponent, modulus, output ready);
endinterface

interface mexp_out_if;
    logic                        valid;
    logic                        ready;
    logic [mexp_pkg::FIELD_W-1:0] value;
    logic                        zero_modulus_error;
    modport source (output valid, value, zero_modulus_error, input ready);
    modport sink   (input valid, value, zero_modulus_error, output ready);
endinterface

FILE: src/mexp_datapath.sv
// Datapath: operand registers, bit-serial modular multiplier, result register.
// Depends on mexp_pkg; driven by mexp_ctrl through command signals.
module mexp_datapath #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
    input  logic                         clk,
    input  logic [mexp_pkg::FIELD_W-1:0] in_base,
    input  logic [mexp_pkg::FIELD_W-1:0] in_exponent,
    input  logic [mexp_pkg::FIELD_W-1:0] in_modulus,
    input  logic                         load,      // capture operands
    input  logic                         red_step,  // one step of base reduction
    input  logic                         b_fold,    // copy reduced base from acc into b
    input  logic                         mul_start, // start product; sel picks r or b
    input  logic                         mul_sel_b,
    input  logic                         mul_step,
    input  logic                         mul_done,  // write acc into r
    input  logic [$clog2(WIDTH)-1:0]     ebit,
    output logic                         m_zero,
    output logic                         e_zero,
    output logic                         e_bit,
    output logic [mexp_pkg::FIELD_W-1:0] r_out
);
    localparam int IW = mexp_pkg::FIELD_W < WIDTH ? mexp_pkg::FIELD_W : WIDTH;

    logic [WIDTH-1:0] b_reg, e_reg, m_reg, r_reg, acc_reg, mb_reg, a_reg;
    logic [WIDTH-1:0] ac2, acs, one_m;

    assign m_zero = (m_reg == '0);
    assign e_zero = (e_reg == '0);
    assign e_bit  = e_reg[ebit];
    assign r_out  = mexp_pkg::FIELD_W'(r_reg);
    assign one_m  = (m_reg == WIDTH'(1)) ? '0 : WIDTH'(1);

    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                 input logic [WIDTH-1:0] b,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] room;
        room = m - b;
        add_mod = (a >= room) ? a - room : a + b;
    endfunction

    assign ac2 = add_mod(acc_reg, acc_reg, m_reg);
    assign acs = mb_reg[WIDTH-1] ? add_mod(ac2, a_reg, m_reg) : ac2;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b_reg   <= WIDTH'(in_base[IW-1:0]);
            e_reg   <= WIDTH'(in_exponent[IW-1:0]);
            m_reg   <= WIDTH'(in_modulus[IW-1:0]);
            // r starts at 1 mod m
            r_reg   <= (WIDTH'(in_modulus[IW-1:0]) == WIDTH'(1)) ? '0 : WIDTH'(1);
            acc_reg <= '0;
            mb_reg  <= WIDTH'(in_base[IW-1:0]);
        end
        else if (red_step)
        begin
            // shift the base in MSB first, reducing at every step
            acc_reg <= mb_reg[WIDTH-1] ? add_mod(ac2, one_m, m_reg) : ac2;
            mb_reg  <= {mb_reg[WIDTH-2:0], 1'b0};
        end
        else if (b_fold)
        begin
            b_reg <= acc_reg;
        end
        else if (mul_start)
        begin
            acc_reg <= '0;
            a_reg   <= mul_sel_b ? b_reg : r_reg;
            mb_reg  <= r_reg;
        end
        else if (mul_step)
        begin
            acc_reg <= acs;
            mb_reg  <= {mb_reg[WIDTH-2:0], 1'b0};
        end
        else if (mul_done)
        begin
            r_reg <= acc_reg;
        end
    end
endmodule

FILE: src/mexp_ctrl.sv
// Controller: sequences base reduction and square/multiply passes.
// Depends on mexp_pkg; commands mexp_datapath.
module mexp_ctrl #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  logic                     m_zero,
    input  logic                     e_zero,
    input  logic                     e_bit,
    output logic                     load,
    output logic                     red_step,
    output logic                     b_fold,
    output logic                     mul_start,
    output logic                     mul_sel_b,
    output logic                     mul_step,
    output logic                     mul_done,
    output logic [$clog2(WIDTH)-1:0] ebit,
    output logic [1:0]               kind      // result kind code from mexp_pkg
);
    localparam int CW = $clog2(WIDTH);
    localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_RED = 3'd2,
                           S_FOLD = 3'd3, S_MSTART = 3'd4, S_MSTEP = 3'd5,
                           S_MDONE = 3'd6, S_OUT = 3'd7;

    logic [2:0]    state_reg;
    logic [CW-1:0] bit_reg;
    logic [CW-1:0] cnt_reg;
    logic          phase_reg;  // 0 square, 1 multiply
    logic [1:0]    kind_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign load      = in_valid && in_ready;
    assign red_step  = (state_reg == S_RED);
    assign b_fold    = (state_reg == S_FOLD);
    assign mul_start = (state_reg == S_MSTART);
    assign mul_sel_b = phase_reg;
    assign mul_step  = (state_reg == S_MSTEP);
    assign mul_done  = (state_reg == S_MDONE);
    assign ebit      = bit_reg;
    assign kind      = kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bit_reg   <= '0;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
            kind_reg  <= mexp_pkg::KIND_NORMAL;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (load)
                        state_reg <= S_CHECK;
                S_CHECK:
                begin
                    kind_reg <= m_zero ? mexp_pkg::KIND_ERROR :
                                (e_zero ? mexp_pkg::KIND_ONE : mexp_pkg::KIND_NORMAL);
                    cnt_reg   <= CW'(WIDTH - 1);
                    bit_reg   <= CW'(WIDTH - 1);
                    phase_reg <= 1'b0;
                    state_reg <= (m_zero || e_zero) ? S_OUT : S_RED;
                end
                S_RED:
                begin
                    // base mod m builds up in acc
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= S_FOLD;
                end
                S_FOLD:
                    state_reg <= S_MSTART;
                S_MSTART:
                begin
                    cnt_reg   <= CW'(WIDTH - 1);
                    state_reg <= S_MSTEP;
                end
                S_MSTEP:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= S_MDONE;
                end
                S_MDONE:
                begin
                    if (!phase_reg && e_bit)
                    begin
                        // square done and exponent bit set: multiply by base
                        phase_reg <= 1'b1;
                        state_reg <= S_MSTART;
                    end
                    else if (bit_reg == '0)
                        state_reg <= S_OUT;
                    else
                    begin
                        bit_reg   <= bit_reg - 1'b1;
                        phase_reg <= 1'b0;
                        state_reg <= S_MSTART;
                    end
                end
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> state_reg == S_CHECK)
        else $error("accepted word did not start check");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");
endmodule

FILE: src/modular_exponentiation.sv
// Modular exponentiation by square-and-multiply, one item at a time.
// A zero modulus or zero exponent goes straight to the result; otherwise the block first reduces
// the base, then runs WIDTH squares plus one multiply per set exponent bit on the bit-serial
// modular multiplier (one product bit per cycle). A new item is taken only after the result is
// accepted. rst_n clears control asynchronously; no clearing pass.
module modular_exponentiation #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
    input logic      clk,
    input logic      rst_n,
    mexp_in_if.sink  in_ch,
    mexp_out_if.source out_ch
);
    logic m_zero, e_zero, e_bit, load, red_step, mul_start, mul_sel_b, mul_step;
    logic mul_done, b_fold;
    logic [$clog2(WIDTH)-1:0] ebit;
    logic [1:0] kind;
    logic [mexp_pkg::FIELD_W-1:0] r_out;

    mexp_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .m_zero, .e_zero, .e_bit, .load, .red_step, .b_fold, .mul_start, .mul_sel_b,
        .mul_step, .mul_done, .ebit, .kind);

    mexp_datapath #(.WIDTH(WIDTH)) u_dp (
        .clk, .in_base(in_ch.base), .in_exponent(in_ch.exponent),
        .in_modulus(in_ch.modulus), .load, .red_step, .b_fold, .mul_start, .mul_sel_b,
        .mul_step, .mul_done, .ebit, .m_zero, .e_zero, .e_bit, .r_out);

    assign out_ch.value = (kind == mexp_pkg::KIND_ERROR) ? '0 :
                          (kind == mexp_pkg::KIND_ONE) ? mexp_pkg::FIELD_W'(1) : r_out;
    assign out_ch.zero_modulus_error = (kind == mexp_pkg::KIND_ERROR);
endmodule

FILE: test/tb.sv
// Testbench for the modular exponentiation block: directed and random requests,
// checked against a square-and-multiply predictor. Depends on mexp_pkg, mexp_if.
`timescale 1ns / 1ps

module tb;
    localparam int W = mexp_pkg::WIDTH_DEF;
    localparam int MAX_LAT = 2 + W + 2 * W * (W + 3) + 8;
    localparam longint CYCLE_LIMIT = 64'd5_000_000;

    typedef struct packed {
        logic [mexp_pkg::FIELD_W-1:0] value;
        logic                         err;
    } power_t;

    logic clk;
    logic rst_n;

    mexp_in_if  req_ch ();
    mexp_out_if res_ch ();

    modular_exponentiation #(.WIDTH(W)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (req_ch.sink),
        .out_ch(res_ch.source)
    );

    power_t pending_powers[$];
    int     mismatches;
    int     results_seen;
    int     items_sent;
    longint cycles;
    bit     quiet;          // no idling on either side
    bit     hold_sink;      // long receiver stall

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // (a * b) mod m, bit-serial with interleaved reduction
    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [63:0] acc;
        acc = 0;
        for (int i = 63; i >= 0; i--)
        begin
            acc = (acc >= m - acc) ? acc - (m - acc) : acc + acc;
            if (b[i])
                acc = (acc >= m - a) ? acc - (m - a) : acc + a;
        end
        return acc;
    endfunction

    function automatic power_t predict_power(logic [mexp_pkg::FIELD_W-1:0] b,
                                             logic [mexp_pkg::FIELD_W-1:0] e,
                                             logic [mexp_pkg::FIELD_W-1:0] m);
        power_t      p;
        logic [63:0] bb, r, mm;
        p.err = 1'b0;
        if (m == 0)
        begin
            p.value = 0;
            p.err   = 1'b1;
            return p;
        end
        if (e == 0)
        begin
            p.value = 1;
            return p;
        end
        mm = {32'd0, m};
        bb = {32'd0, b} % mm;
        r  = 64'd1 % mm;
        for (int i = W - 1; i >= 0; i--)
        begin
            r = mulmod(r, r, mm);
            if (e[i])
                r = mulmod(r, bb, mm);
        end
        p.value = r[mexp_pkg::FIELD_W-1:0];
        return p;
    endfunction

    task automatic idle_burst();
        repeat ($urandom_range(16, 1)) @(negedge clk);
    endtask

    task automatic send_power(logic [mexp_pkg::FIELD_W-1:0] b,
                              logic [mexp_pkg::FIELD_W-1:0] e,
                              logic [mexp_pkg::FIELD_W-1:0] m);
        if (!quiet && $urandom_range(3, 0) == 0)
        begin
            req_ch.valid = 1'b0;
            idle_burst();
        end
        req_ch.base     = b;
        req_ch.exponent = e;
        req_ch.modulus  = m;
        req_ch.valid    = 1'b1;
        pending_powers  = {pending_powers, predict_power(b, e, m)};
        items_sent++;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_powers.size() != 0)
            @(negedge clk);
        repeat (MAX_LAT) @(negedge clk);
    endtask

    // receiver: random stalls, a long hold on request
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
                res_ch.ready <= 1'b0;
            else if (!quiet && $urandom_range(5, 0) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(15, 0)) @(negedge clk);
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // check each result word against the oldest prediction
    initial
    begin
        power_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (pending_powers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result value=%h err=%b",
                                 res_ch.value, res_ch.zero_modulus_error);
                end
                else
                begin
                    want = pending_powers.pop_front();
                    if (res_ch.value !== want.value ||
                        res_ch.zero_modulus_error !== want.err)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected value=%h err=%b, got value=%h err=%b",
                                     want.value, want.err, res_ch.value,
                                     res_ch.zero_modulus_error);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_power(32'd0, 32'd0, 32'd0);
        send_power(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_power(32'd7, 32'd0, 32'd1);
        send_power(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_power(32'd5, 32'd3, 32'd1);
        send_power(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        send_power(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_power(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_power(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
        send_power(32'd0, 32'd5, 32'd13);
        send_power(32'd2, 32'd10, 32'd1000);
        send_power(32'd3, 32'h8000_0000, 32'h7FFF_FFFF);
        send_power(32'h8000_0000, 32'd1, 32'h8000_0001);
        send_power(32'd123456789, 32'd1, 32'd2);
        send_power(32'd2, 32'd31, 32'hFFFF_FFFF);
        send_power(32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_FFC5);
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [mexp_pkg::FIELD_W-1:0] b, e, m;
        for (int i = 0; i < count; i++)
        begin
            b = $urandom();
            e = $urandom();
            m = $urandom();
            case ($urandom_range(9, 0))
                0: m = 0;
                1: e = 0;
                2: m = $urandom_range(3, 1);
                3: e = $urandom_range(16, 1);
                4: m = m | 32'h8000_0000;
                default: ;
            endcase
            send_power(b, e, m);
        end
    endtask

    // stall the receiver long enough that the input must back up
    task automatic test_backpressure();
        fork
            begin
                hold_sink = 1'b1;
                repeat (3 * MAX_LAT) @(negedge clk);
                hold_sink = 1'b0;
            end
            test_random(4);
        join
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.base = '0;
        req_ch.exponent = '0;
        req_ch.modulus = '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        quiet = 1'b0;
        hold_sink = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(120);
        wait_drained();   // sender pauses until every result is back
        test_backpressure();
        test_random(100);
        quiet = 1'b1;
        test_random(40);
        wait_drained();

        $display("Sent %0d requests (zero modulus, zero exponent, extremes, random), %0d results",
                 items_sent, results_seen);
        if (mismatches == 0 && pending_powers.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
